// ===== hdl/rfre_pkg.sv =====
// Shared types and constants for the RIP/RIPng frame route extractor.
// Used by every module of the block; depends on nothing.
package rfre_pkg;

    // Default limits.
    localparam int MAX_FRAME_BYTES_DEF = 2048;
    localparam int QUEUE_DEPTH_DEF     = 4;

    // Frame layout.
    localparam int ENTRY_BYTES = 20;
    localparam int ENTRY_BASE  = 46;
    localparam int OFF_ETHERTYPE_VER = 14;
    localparam int OFF_SRC_FIRST  = 26;
    localparam int OFF_DST_LAST   = 33;
    localparam int OFF_V4_LEN_HI  = 38;
    localparam int OFF_V4_LEN_LO  = 39;
    localparam int OFF_V4_CMD     = 42;
    localparam int OFF_V4_VER     = 43;
    localparam int OFF_V4_HDR     = 57;
    localparam int OFF_NG_LEN_HI  = 58;
    localparam int OFF_NG_LEN_LO  = 59;
    localparam int OFF_NG_CMD     = 62;
    localparam int OFF_NG_HDR     = 65;

    // Result kinds.
    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_V4     = 3'd1;
    localparam logic [2:0] KIND_NG     = 3'd2;
    localparam logic [2:0] KIND_AUTH   = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;

    // Authentication modes.
    localparam logic [1:0] AUTH_NONE   = 2'd0;
    localparam logic [1:0] AUTH_SIMPLE = 2'd1;
    localparam logic [1:0] AUTH_MD5    = 2'd2;
    localparam logic [1:0] AUTH_OTHER  = 2'd3;

    // One result item, all fields but the run mark.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  command;
        logic [7:0]  version;
        logic [1:0]  auth_type;
        logic [15:0] family;
        logic [15:0] route_tag;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [63:0] mask_hop;
        logic [31:0] metric;
        logic [7:0]  prefix_len;
    } res_t;

    // Work record from the parser to the output side for one byte.
    typedef struct packed {
        logic has_data;
        logic frame_end;
        res_t row;
    } rec_t;

endpackage

// ===== hdl/rfre_front.sv =====
// Byte parser: offset tracking, field capture, entry assembly and result build.
// Depends on rfre_pkg.
module rfre_front
    import rfre_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] byte_value,
    input  logic       frame_end,
    input  logic       push_ok,
    output logic       push,
    output rec_t       push_rec
);

    localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = ((OFF_W > 16) ? OFF_W : 16) + 2;
    localparam int IDX_W = $clog2(ENTRY_BYTES);

    logic [OFF_W-1:0]  off_reg, off_next;
    logic [OFF_W-1:0]  ebase_reg, ebase_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              ipv4_reg, ipv4_next;
    logic [15:0]       len_reg, len_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic [7:0]        ver_reg, ver_next;
    logic [1:0]        auth_reg, auth_next;
    logic [63:0]       sd_reg, sd_next;
    logic [7:0]        buf_reg [ENTRY_BYTES];
    logic [7:0]        cur [ENTRY_BYTES];

    logic              take, in_range, in_entry, entry_last, ipv4_now;
    logic              hdr_v4, hdr_ng, ent_ok;
    logic [1:0]        auth_new;
    logic [2:0]        ent_kind;
    logic [CMP_W-1:0]  eb, ln;
    rec_t              rec;

    assign take = byte_valid && push_ok;

    // Decode the current byte against the frame layout.
    always_comb
    begin
        in_range = off_reg < OFF_W'(MAX_FRAME_BYTES);
        in_entry = off_reg >= OFF_W'(ENTRY_BASE);
        ipv4_now = (off_reg == OFF_W'(OFF_ETHERTYPE_VER)) ? (byte_value[7:4] == 4'd4)
                                                          : ipv4_reg;
        for (int i = 0; i < ENTRY_BYTES; i++)
        begin
            cur[i] = (in_entry && idx_reg == IDX_W'(i)) ? byte_value : buf_reg[i];
        end
        entry_last = in_entry && (idx_reg == IDX_W'(ENTRY_BYTES - 1));
        hdr_v4 = in_range && ipv4_now && (off_reg == OFF_W'(OFF_V4_HDR));
        hdr_ng = in_range && !ipv4_now && (off_reg == OFF_W'(OFF_NG_HDR));

        // Authentication type from the first entry.
        auth_new = AUTH_NONE;
        if (ver_reg == 8'd2 && cur[0] == 8'hFF && cur[1] == 8'hFF)
        begin
            if (cur[2] == 8'd0 && cur[3] == 8'd2)
                auth_new = AUTH_SIMPLE;
            else if (cur[2] == 8'd0 && cur[3] == 8'd3)
                auth_new = AUTH_MD5;
            else
                auth_new = AUTH_OTHER;
        end

        // Entry bounds against the UDP length.
        eb = CMP_W'(ebase_reg);
        ln = CMP_W'(len_reg);
        ent_ok = 1'b0;
        ent_kind = KIND_V4;
        if (in_range && entry_last)
        begin
            if (ipv4_now)
            begin
                if (ver_reg == 8'd1)
                    ent_ok = (eb + CMP_W'(12)) < ln;
                else if (ver_reg == 8'd2 && ebase_reg != '0)
                begin
                    if (auth_reg == AUTH_SIMPLE)
                        ent_ok = (eb + CMP_W'(32)) <= ln;
                    else if (auth_reg == AUTH_MD5)
                    begin
                        ent_ok = (eb + CMP_W'(12)) < ln;
                        if (cur[0] == 8'hFF && cur[1] == 8'hFF)
                            ent_kind = KIND_AUTH;
                    end
                end
            end
            else if (ebase_reg != '0)
            begin
                ent_ok = eb < (ln + CMP_W'(8));
                ent_kind = KIND_NG;
            end
        end
    end

    // Build the record for this byte.
    always_comb
    begin
        rec = '0;
        rec.frame_end = frame_end;
        rec.row.command = cmd_reg;
        rec.row.version = ipv4_now ? ver_reg : 8'd0;
        rec.row.auth_type = auth_reg;
        if (hdr_v4)
        begin
            rec.has_data = 1'b1;
            rec.row.kind = KIND_HEADER;
            rec.row.auth_type = auth_new;
            rec.row.addr_hi = {32'd0, sd_reg[63:32]};
            rec.row.addr_lo = {32'd0, sd_reg[31:0]};
            if (auth_new == AUTH_MD5)
            begin
                rec.row.family = {cur[4], cur[5]};
                rec.row.route_tag = {8'd0, cur[7]};
                rec.row.prefix_len = cur[6];
                rec.row.metric = {cur[8], cur[9], cur[10], cur[11]};
            end
        end
        else if (hdr_ng)
        begin
            rec.has_data = 1'b1;
            rec.row.kind = KIND_HEADER;
        end
        else if (ent_ok)
        begin
            rec.has_data = 1'b1;
            rec.row.kind = ent_kind;
            case (ent_kind)
                KIND_V4:
                begin
                    rec.row.family = {cur[0], cur[1]};
                    rec.row.route_tag = {cur[2], cur[3]};
                    rec.row.addr_lo = {32'd0, cur[4], cur[5], cur[6], cur[7]};
                    rec.row.mask_hop = {cur[8], cur[9], cur[10], cur[11],
                                        cur[12], cur[13], cur[14], cur[15]};
                    rec.row.metric = {cur[16], cur[17], cur[18], cur[19]};
                end
                KIND_AUTH:
                begin
                    rec.row.family = {cur[0], cur[1]};
                    rec.row.route_tag = {cur[2], cur[3]};
                    rec.row.addr_hi = {cur[4], cur[5], cur[6], cur[7],
                                       cur[8], cur[9], cur[10], cur[11]};
                    rec.row.addr_lo = {cur[12], cur[13], cur[14], cur[15],
                                       cur[16], cur[17], cur[18], cur[19]};
                end
                default:
                begin
                    rec.row.addr_hi = {cur[0], cur[1], cur[2], cur[3],
                                       cur[4], cur[5], cur[6], cur[7]};
                    rec.row.addr_lo = {cur[8], cur[9], cur[10], cur[11],
                                       cur[12], cur[13], cur[14], cur[15]};
                    rec.row.route_tag = {cur[16], cur[17]};
                    rec.row.prefix_len = cur[18];
                    rec.row.metric = {24'd0, cur[19]};
                end
            endcase
        end
    end

    assign push = take && (rec.has_data || rec.frame_end);
    assign push_rec = rec;

    // Next-state logic for the parse context.
    always_comb
    begin
        off_next = off_reg;
        ebase_next = ebase_reg;
        idx_next = idx_reg;
        ipv4_next = ipv4_reg;
        len_next = len_reg;
        cmd_next = cmd_reg;
        ver_next = ver_reg;
        auth_next = auth_reg;
        sd_next = sd_reg;
        if (take)
        begin
            if (in_range)
            begin
                off_next = off_reg + OFF_W'(1);
                ipv4_next = ipv4_now;
                if (ipv4_now)
                begin
                    if (off_reg >= OFF_W'(OFF_SRC_FIRST) && off_reg <= OFF_W'(OFF_DST_LAST))
                        sd_next = {sd_reg[55:0], byte_value};
                    else if (off_reg == OFF_W'(OFF_V4_LEN_HI))
                        len_next = {byte_value, 8'd0};
                    else if (off_reg == OFF_W'(OFF_V4_LEN_LO))
                        len_next = {len_reg[15:8], byte_value};
                    else if (off_reg == OFF_W'(OFF_V4_CMD))
                        cmd_next = byte_value;
                    else if (off_reg == OFF_W'(OFF_V4_VER))
                        ver_next = byte_value;
                end
                else
                begin
                    if (off_reg == OFF_W'(OFF_NG_LEN_HI))
                        len_next = {byte_value, 8'd0};
                    else if (off_reg == OFF_W'(OFF_NG_LEN_LO))
                        len_next = {len_reg[15:8], byte_value};
                    else if (off_reg == OFF_W'(OFF_NG_CMD))
                        cmd_next = byte_value;
                end
                if (hdr_v4)
                    auth_next = auth_new;
                if (in_entry)
                begin
                    idx_next = entry_last ? '0 : idx_reg + IDX_W'(1);
                    if (entry_last)
                        ebase_next = ebase_reg + OFF_W'(ENTRY_BYTES);
                end
            end
            if (frame_end)
            begin
                off_next = '0;
                ebase_next = '0;
                idx_next = '0;
                ipv4_next = 1'b0;
                len_next = '0;
                cmd_next = '0;
                ver_next = '0;
                auth_next = AUTH_NONE;
                sd_next = '0;
            end
        end
    end

    // Parse context registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
            ebase_reg <= '0;
            idx_reg <= '0;
            ipv4_reg <= 1'b0;
            len_reg <= '0;
            cmd_reg <= '0;
            ver_reg <= '0;
            auth_reg <= AUTH_NONE;
            sd_reg <= '0;
        end
        else
        begin
            off_reg <= off_next;
            ebase_reg <= ebase_next;
            idx_reg <= idx_next;
            ipv4_reg <= ipv4_next;
            len_reg <= len_next;
            cmd_reg <= cmd_next;
            ver_reg <= ver_next;
            auth_reg <= auth_next;
            sd_reg <= sd_next;
        end
    end

    // Entry byte buffer, filled cyclically from the first entry byte.
    always_ff @(posedge clk)
    begin
        if (take && in_range && in_entry)
            buf_reg[idx_reg] <= byte_value;
    end

endmodule

// ===== hdl/rfre_queue.sv =====
// Short record queue between the byte parser and the output side.
// Depends on rfre_pkg.
module rfre_queue
    import rfre_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rec_t push_rec,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output rec_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full = cnt_reg == CNT_W'(DEPTH);
    assign not_empty = cnt_reg != '0;
    assign head = slot_reg[rd_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        if (pop)
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_rec;
    end

endmodule

// ===== hdl/rfre_back.sv =====
// Output side: splits each record into its result beats and holds the output register.
// Depends on rfre_pkg.
module rfre_back
    import rfre_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic not_empty,
    input  rec_t head,
    output logic pop,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_row,
    output logic out_last
);

    logic valid_reg, valid_next;
    logic phase_reg, phase_next;
    logic last_reg, last_next;
    res_t row_reg, row_next;
    logic load;

    assign load = not_empty && (!valid_reg || out_ready);

    // Pick the next beat from the queue head.
    always_comb
    begin
        valid_next = valid_reg && !out_ready;
        phase_next = phase_reg;
        last_next = last_reg;
        row_next = row_reg;
        pop = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            if (head.has_data && !phase_reg)
            begin
                row_next = head.row;
                last_next = !head.frame_end;
                if (head.frame_end)
                    phase_next = 1'b1;
                else
                    pop = 1'b1;
            end
            else
            begin
                row_next = '0;
                row_next.kind = KIND_END;
                last_next = 1'b1;
                phase_next = 1'b0;
                pop = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_row = row_reg;
    assign out_last = last_reg;

endmodule

// ===== hdl/rip_frame_route_extractor.sv =====
// RIP/RIPng frame route extractor: takes an untagged Ethernet frame one byte per beat
// and reports a header result followed by one result per route entry that passes the
// version and length checks, plus a frame-end result. The parser takes one byte every
// cycle while the record queue is not full. A byte yields at most two beats (a data
// result and the frame-end result); the output side sends one beat per cycle while
// m_tready is high, so a byte that carries both needs an extra beat there, absorbed by
// a record queue of QUEUE_DEPTH entries between the parser and the output register.
// Depends on rfre_pkg, rfre_front, rfre_queue and rfre_back.
module rip_frame_route_extractor
    import rfre_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // byte_value[7:0]
    input  logic         s_tlast,   // frame_end
    output logic         m_tvalid,
    input  logic         m_tready,
    // command[7:0], version[15:8], auth_type[17:16], family[33:18], route_tag[49:34],
    // addr_hi[113:50], addr_lo[177:114], mask_hop[241:178], metric[273:242],
    // prefix_len[281:274], zero fill[287:282]
    output logic [287:0] m_tdata,
    output logic [2:0]   m_tuser,   // kind[2:0]
    output logic         m_tlast    // last_of_run
);

    logic push, full, pop, not_empty;
    rec_t push_rec, head;
    res_t row;

    assign s_tready = !full;

    rfre_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_tvalid),
        .byte_value (s_tdata),
        .frame_end  (s_tlast),
        .push_ok    (!full),
        .push       (push),
        .push_rec   (push_rec)
    );

    rfre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    rfre_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_row   (row),
        .out_last  (m_tlast)
    );

    // Pack the result fields onto the stream.
    assign m_tuser = row.kind;
    assign m_tdata = {6'd0, row.prefix_len, row.metric, row.mask_hop, row.addr_lo,
                      row.addr_hi, row.route_tag, row.family, row.auth_type,
                      row.version, row.command};

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the RIP/RIPng frame route extractor.
// Drives byte beats into the block and checks every result beat against a predictor.
// Depends on rfre_pkg and rip_frame_route_extractor.
module testbench;
    import rfre_pkg::*;

    // One expected result beat.
    typedef struct {
        logic [2:0]   kind;
        logic [287:0] data;
        logic         last;
    } route_beat_t;

    // Frame parser predictor and the queue of route results it expects.
    class route_scoreboard;
        route_beat_t pending[$];
        int          errors;
        int          offset;
        bit          v4;
        logic [15:0] udp_len;
        logic [7:0]  cmd;
        logic [7:0]  ver;
        logic [1:0]  auth;
        logic [63:0] addrs;
        logic [7:0]  ent[20];

        function void clear();
            offset = 0;
            v4 = 1'b0;
            udp_len = '0;
            cmd = '0;
            ver = '0;
            auth = AUTH_NONE;
            addrs = '0;
            foreach (ent[i]) ent[i] = '0;
        endfunction

        function logic [63:0] be(int first, int count);
            logic [63:0] v;
            v = '0;
            for (int i = 0; i < count; i++) v = (v << 8) | {56'd0, ent[first + i]};
            return v;
        endfunction

        // Packs one result row the way m_tdata carries it.
        function void push(logic [2:0] kind, res_t r);
            route_beat_t b;
            b.kind = kind;
            b.data = {6'd0, r.prefix_len, r.metric, r.mask_hop, r.addr_lo, r.addr_hi,
                      r.route_tag, r.family, r.auth_type, r.version, r.command};
            b.last = 1'b0;
            pending.push_back(b);
        endfunction

        function res_t context_row();
            res_t r;
            r = '0;
            r.command = cmd;
            r.version = v4 ? ver : 8'd0;
            r.auth_type = auth;
            return r;
        endfunction

        function void v4_header();
            res_t r;
            logic [63:0] md5;
            auth = AUTH_NONE;
            if (ver == 8'd2 && ent[0] == 8'hFF && ent[1] == 8'hFF)
            begin
                if (ent[2] == 8'd0 && ent[3] == 8'd2) auth = AUTH_SIMPLE;
                else if (ent[2] == 8'd0 && ent[3] == 8'd3) auth = AUTH_MD5;
                else auth = AUTH_OTHER;
            end
            md5 = (auth == AUTH_MD5) ? be(4, 8) : 64'd0;
            r = context_row();
            r.family = md5[63:48];
            r.route_tag = {8'd0, md5[39:32]};
            r.addr_hi = {32'd0, addrs[63:32]};
            r.addr_lo = {32'd0, addrs[31:0]};
            r.metric = md5[31:0];
            r.prefix_len = md5[47:40];
            push(KIND_HEADER, r);
        endfunction

        function void entry_done(int k);
            res_t r;
            int len;
            bit hit;
            logic [2:0] kind;
            len = int'(udp_len);
            hit = 1'b0;
            kind = KIND_V4;
            if (v4)
            begin
                if (ver == 8'd1)
                begin
                    if (20 * k < len - 12) hit = 1'b1;
                end
                else if (ver == 8'd2 && k >= 1)
                begin
                    if (auth == AUTH_SIMPLE && 46 + 20 * k + 20 <= 34 + len) hit = 1'b1;
                    else if (auth == AUTH_MD5 && 20 * (k - 1) < len - 32)
                    begin
                        hit = 1'b1;
                        if (ent[0] == 8'hFF && ent[1] == 8'hFF) kind = KIND_AUTH;
                    end
                end
            end
            else if (k >= 1 && 20 * (k - 1) < len - 12)
            begin
                hit = 1'b1;
                kind = KIND_NG;
            end
            if (!hit) return;
            r = context_row();
            if (kind == KIND_V4)
            begin
                r.family = 16'(be(0, 2));
                r.route_tag = 16'(be(2, 2));
                r.addr_lo = be(4, 4);
                r.mask_hop = be(8, 8);
                r.metric = 32'(be(16, 4));
            end
            else if (kind == KIND_AUTH)
            begin
                r.family = 16'(be(0, 2));
                r.route_tag = 16'(be(2, 2));
                r.addr_hi = be(4, 8);
                r.addr_lo = be(12, 8);
            end
            else
            begin
                r.addr_hi = be(0, 8);
                r.addr_lo = be(8, 8);
                r.route_tag = 16'(be(16, 2));
                r.prefix_len = ent[18];
                r.metric = {24'd0, ent[19]};
            end
            push(kind, r);
        endfunction

        // Notes one accepted input byte and queues what it should produce.
        function void note_byte(logic [7:0] b, logic fend);
            int n0;
            int off;
            res_t r;
            n0 = pending.size();
            off = offset;
            if (off < MAX_FRAME_BYTES_DEF)
            begin
                if (off == 14) v4 = (b[7:4] == 4'd4);
                if (v4)
                begin
                    if (off >= 26 && off <= 33) addrs = (addrs << 8) | {56'd0, b};
                    else if (off == 38) udp_len = {b, 8'd0};
                    else if (off == 39) udp_len[7:0] = b;
                    else if (off == 42) cmd = b;
                    else if (off == 43) ver = b;
                end
                else
                begin
                    if (off == 58) udp_len = {b, 8'd0};
                    else if (off == 59) udp_len[7:0] = b;
                    else if (off == 62) cmd = b;
                end
                if (off >= 46) ent[(off - 46) % 20] = b;
                if (v4 && off == 57) v4_header();
                else if (!v4 && off == 65) push(KIND_HEADER, context_row());
                if (off >= 46 && (off - 46) % 20 == 19) entry_done((off - 46) / 20);
                offset++;
            end
            if (fend)
            begin
                r = '0;
                push(KIND_END, r);
                clear();
            end
            if (pending.size() > n0) pending[$].last = 1'b1;
        endfunction

        // Compares one accepted result beat with the oldest expectation.
        function void check(logic [2:0] kind, logic [287:0] data, logic last);
            route_beat_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected beat kind=%0d data=%h", $time, kind, data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (kind !== e.kind)
            begin
                $display("%0t: kind expected %0d actual %0d", $time, e.kind, kind);
                errors++;
            end
            if (data !== e.data)
            begin
                $display("%0t: tdata expected %h actual %h", $time, e.data, data);
                errors++;
            end
            if (last !== e.last)
            begin
                $display("%0t: tlast expected %0d actual %0d", $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [287:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    route_scoreboard sb;
    bit  calm;
    int  hold_cycles;
    int  byte_count;
    logic [7:0] frame_buf[$];

    rip_frame_route_extractor uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // Clock with period 10.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Sends one byte beat, with an optional random gap in front.
    task automatic send_byte(input logic [7:0] b, input logic fend);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= fend;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_byte(b, fend);
        byte_count++;
        @(negedge clk);
    endtask

    // Sends the assembled frame; the frame end mark goes on its last byte.
    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        frame_buf.delete();
    endtask

    // Builds a frame. ng selects RIPng; auth: 0 none, 1 simple, 2 MD5 with trailer.
    task automatic build_frame(input bit ng, input logic [7:0] ver, input int auth,
                               input int entries, input bit fit_len);
        int total;
        int len;
        total = 46 + 20 * entries;
        for (int i = 0; i < total; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf[14] = ng ? {4'h6, frame_buf[14][3:0]} : {4'h4, frame_buf[14][3:0]};
        if (!ng)
        begin
            len = fit_len ? total - 34 : int'($urandom_range(0, 65535));
            if (auth == 2 && fit_len) len = total - 34 - 20;
            frame_buf[38] = len[15:8];
            frame_buf[39] = len[7:0];
            frame_buf[42] = 8'($urandom_range(1, 2));
            frame_buf[43] = ver;
            if (auth > 0 && total >= 66)
            begin
                frame_buf[46] = 8'hFF;
                frame_buf[47] = 8'hFF;
                frame_buf[48] = 8'h00;
                frame_buf[49] = (auth == 1) ? 8'd2 : 8'd3;
            end
            if (auth == 2 && entries >= 3)
            begin
                frame_buf[total - 20] = 8'hFF;
                frame_buf[total - 19] = 8'hFF;
            end
        end
        else
        begin
            len = fit_len ? total - 54 : int'($urandom_range(0, 65535));
            frame_buf[58] = len[15:8];
            frame_buf[59] = len[7:0];
            frame_buf[62] = 8'($urandom_range(1, 2));
        end
    endtask

    // Output side: random stalls, a long hold-off when asked, and checking.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready) sb.check(m_tuser, m_tdata, m_tlast);

    // Run limit.
    initial
    begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus.
    initial
    begin
        int idle;
        sb = new();
        sb.clear();
        calm = 0;
        hold_cycles = 0;
        byte_count = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tlast = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: one-byte frames with both extreme bytes, a short frame,
        // and one frame of each protocol variant.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        build_frame(0, 8'd1, 0, 0, 1);
        frame_buf = frame_buf[0:29];
        send_frame();
        build_frame(0, 8'd1, 0, 1, 1);
        send_frame();
        build_frame(0, 8'd2, 0, 1, 1);
        send_frame();
        build_frame(0, 8'd2, 1, 2, 1);
        send_frame();
        build_frame(0, 8'd2, 2, 3, 1);
        send_frame();
        build_frame(1, 8'd0, 0, 2, 1);
        send_frame();
        build_frame(0, 8'd2, 3, 2, 1);
        frame_buf[49] = 8'd7;
        send_frame();

        // Receiver holds off while the sender keeps offering route entries.
        hold_cycles = 300;
        build_frame(0, 8'd1, 0, 4, 1);
        send_frame();

        // Random frames: mostly well-formed, some with random length or a cut end.
        while (byte_count < 780)
        begin
            int pick;
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1: build_frame(0, 8'd1, 0, $urandom_range(0, 4), $urandom_range(0, 3) != 0);
                2:    build_frame(0, 8'd2, 1, $urandom_range(1, 4), $urandom_range(0, 3) != 0);
                3, 4: build_frame(0, 8'd2, 2, $urandom_range(1, 5), $urandom_range(0, 3) != 0);
                5, 6: build_frame(1, 8'd0, 0, $urandom_range(1, 4), $urandom_range(0, 3) != 0);
                7:    build_frame(0, 8'($urandom_range(0, 255)), $urandom_range(0, 3), 2, 0);
                default:
                begin
                    build_frame(1'($urandom_range(0, 1)), 8'd1, 0, 3, 1);
                    frame_buf = frame_buf[0:$urandom_range(0, frame_buf.size() - 1)];
                end
            endcase
            send_frame();
            if (byte_count > 680) calm = 1;
        end

        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        idle = 0;
        while (sb.pending.size() != 0 && idle < 10000)
        begin
            @(posedge clk);
            idle++;
        end
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/rfre_pkg.sv
hdl/rfre_front.sv
hdl/rfre_queue.sv
hdl/rfre_back.sv
hdl/rip_frame_route_extractor.sv
test/testbench.sv
